FILE: hdl/hsq_pkg.sv
// Shared types and constants for the heterosquare check block.
// No dependencies; used by hsq_accum and heterosquare_check.
package hsq_pkg;

  // Default parameter values
  localparam int DEF_MAX_SIZE      = 16;
  localparam int DEF_ELEMENT_WIDTH = 16;

  // Side length register
  localparam int                SIZE_W     = 5;
  localparam logic [SIZE_W-1:0] RESET_SIZE = 5'd3;

  // Controller states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FLUSH,
    ST_FETCH_A,
    ST_LOAD_A,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Source of a sum on the check read port
  typedef enum logic [1:0] {
    SRC_ROW,
    SRC_COL,
    SRC_MAIN,
    SRC_ANTI
  } sum_src_t;

  // Status from the accumulator to the controller
  typedef struct packed {
    logic last_item;   // accepted element would close the matrix
    logic wb_pend;     // column writeback still in flight
  } acc_stat_t;

endpackage

FILE: hdl/hsq_accum.sv
// Sum accumulator: row, column and diagonal sums of one matrix, with the
// row and column sums held in synchronous memories. Depends on hsq_pkg.
module hsq_accum #(
  parameter int MAX_SIZE      = hsq_pkg::DEF_MAX_SIZE,
  parameter int ELEMENT_WIDTH = hsq_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           clr,
  input  logic [$clog2(MAX_SIZE+1)-1:0]                  size_n,
  input  logic                                           in_fire,
  input  logic signed [ELEMENT_WIDTH-1:0]                in_elem,
  output hsq_pkg::acc_stat_t                             stat,
  input  logic                                           rd_en,
  input  logic [$clog2(2*MAX_SIZE+2)-1:0]                rd_idx,
  output logic signed [ELEMENT_WIDTH+$clog2(MAX_SIZE+1)-1:0] rd_sum
);

  localparam int IDX_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int N_W    = $clog2(MAX_SIZE + 1);
  localparam int SUM_W  = ELEMENT_WIDTH + N_W;
  localparam int SIDX_W = $clog2(2 * MAX_SIZE + 2);

  // Sum memories
  logic signed [SUM_W-1:0] col_mem [MAX_SIZE];
  logic signed [SUM_W-1:0] row_mem [MAX_SIZE];

  logic [IDX_W-1:0]        row_pos_r, row_pos_nxt;
  logic [IDX_W-1:0]        col_pos_r, col_pos_nxt;
  logic signed [SUM_W-1:0] row_acc_r, row_total;
  logic signed [SUM_W-1:0] diag_main_r, diag_main_nxt;
  logic signed [SUM_W-1:0] diag_anti_r, diag_anti_nxt;

  // Column read-modify-write stage
  logic                    s2_valid_r;
  logic signed [SUM_W-1:0] s2_x_r;
  logic [IDX_W-1:0]        s2_col_r;
  logic                    s2_first_r;
  logic signed [SUM_W-1:0] col_rd_r;
  logic signed [SUM_W-1:0] row_rd_r;
  logic signed [SUM_W-1:0] col_new;

  // Check read decode
  hsq_pkg::sum_src_t       rd_src;
  hsq_pkg::sum_src_t       rd_src_r;
  logic [SIDX_W-1:0]       n_x, n2_x, col_off;
  logic                    col_rd_en, row_rd_en;
  logic [IDX_W-1:0]        col_rd_addr;

  logic signed [SUM_W-1:0] x_ext;
  logic                    col_last, row_last, first_item, on_main, on_anti;

  // Position decode
  assign x_ext      = {{(SUM_W-ELEMENT_WIDTH){in_elem[ELEMENT_WIDTH-1]}}, in_elem};
  assign col_last   = (N_W'(col_pos_r) == size_n - 1'b1);
  assign row_last   = (N_W'(row_pos_r) == size_n - 1'b1);
  assign first_item = (row_pos_r == '0) && (col_pos_r == '0);
  assign on_main    = (row_pos_r == col_pos_r);
  assign on_anti    = ((N_W+1)'(row_pos_r) + (N_W+1)'(col_pos_r))
                      == ((N_W+1)'(size_n) - 1'b1);

  assign stat.last_item = col_last && row_last;
  assign stat.wb_pend   = s2_valid_r;

  // Running sums; a new row or matrix starts from zero
  always_comb begin
    row_total     = (col_pos_r == '0 ? '0 : row_acc_r) + x_ext;
    diag_main_nxt = (first_item ? '0 : diag_main_r) + (on_main ? x_ext : '0);
    diag_anti_nxt = (first_item ? '0 : diag_anti_r) + (on_anti ? x_ext : '0);
    col_pos_nxt   = col_last ? '0 : col_pos_r + 1'b1;
    row_pos_nxt   = row_pos_r;
    if (col_last) begin
      row_pos_nxt = row_last ? '0 : row_pos_r + 1'b1;
    end
  end

  // Advance positions; a size write drops the partial matrix
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r  <= '0;
      col_pos_r  <= '0;
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= in_fire;
      if (clr) begin
        row_pos_r <= '0;
        col_pos_r <= '0;
      end else if (in_fire) begin
        row_pos_r <= row_pos_nxt;
        col_pos_r <= col_pos_nxt;
      end
    end
  end

  // Hold sums and the writeback payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_acc_r   <= row_total;
      diag_main_r <= diag_main_nxt;
      diag_anti_r <= diag_anti_nxt;
      s2_x_r      <= x_ext;
      s2_col_r    <= col_pos_r;
      s2_first_r  <= (row_pos_r == '0);
    end
  end

  // Decode the check read index into memory and register sources
  always_comb begin
    n_x     = SIDX_W'(size_n);
    n2_x    = n_x + n_x;
    col_off = rd_idx - n_x;
    if (rd_idx < n_x) begin
      rd_src = hsq_pkg::SRC_ROW;
    end else if (rd_idx < n2_x) begin
      rd_src = hsq_pkg::SRC_COL;
    end else if (rd_idx == n2_x) begin
      rd_src = hsq_pkg::SRC_MAIN;
    end else begin
      rd_src = hsq_pkg::SRC_ANTI;
    end
    col_rd_en   = in_fire || (rd_en && rd_src == hsq_pkg::SRC_COL);
    col_rd_addr = in_fire ? col_pos_r : col_off[IDX_W-1:0];
    row_rd_en   = rd_en && rd_src == hsq_pkg::SRC_ROW;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_src_r <= rd_src;
    end
  end

  // Column memory: read at acceptance, write back in the next cycle
  assign col_new = (s2_first_r ? '0 : col_rd_r) + s2_x_r;

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      col_mem[s2_col_r] <= col_new;
    end
    if (col_rd_en) begin
      col_rd_r <= col_mem[col_rd_addr];
    end
  end

  // Row memory: store each finished row
  always_ff @(posedge clk) begin
    if (in_fire && col_last) begin
      row_mem[row_pos_r] <= row_total;
    end
    if (row_rd_en) begin
      row_rd_r <= row_mem[rd_idx[IDX_W-1:0]];
    end
  end

  // Select the sum for the check
  always_comb begin
    case (rd_src_r)
      hsq_pkg::SRC_ROW:  rd_sum = row_rd_r;
      hsq_pkg::SRC_COL:  rd_sum = col_rd_r;
      hsq_pkg::SRC_MAIN: rd_sum = diag_main_r;
      default:           rd_sum = diag_anti_r;
    endcase
  end

endmodule

FILE: hdl/heterosquare_check.sv
// Heterosquare check top level: input channel, size register, pairwise
// distinctness scan and result register. Depends on hsq_pkg, hsq_accum.
//
// Usage:
//   Elements of an N x N matrix enter in row-major order on the in_ channel
//   (in_valid / in_stall), one per cycle while the matrix loads. N comes
//   from cfg_square_size (0 acts as 1, values above MAX_SIZE act as
//   MAX_SIZE); a cfg write drops any partial matrix, and in_stall stays
//   high while cfg_valid is up. Reset leaves N = 3.
//   The last element of a matrix starts a check of the 2N+2 row, column
//   and diagonal sums. Every sum is compared against every later sum, one
//   compare per cycle while no new first sum is being fetched; row and
//   column sums are read from their memories through single read ports,
//   diagonal sums from registers. The check stops at the first equal
//   pair. In_stall stays high until the flag is loaded into the output
//   register; then the next matrix can start at once, even while the
//   receiver still stalls the previous result on out_. A result waiting
//   on out_ holds the block only when the next check has finished.
//   Reset clears all control state; no memory clearing pass is needed.
module heterosquare_check #(
  parameter int MAX_SIZE      = hsq_pkg::DEF_MAX_SIZE,
  parameter int ELEMENT_WIDTH = hsq_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [ELEMENT_WIDTH-1:0]   in_element_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_is_heterosquare,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hsq_pkg::SIZE_W-1:0]        cfg_square_size
);

  localparam int N_W    = $clog2(MAX_SIZE + 1);
  localparam int SUM_W  = ELEMENT_WIDTH + N_W;
  localparam int SIDX_W = $clog2(2 * MAX_SIZE + 2);

  hsq_pkg::state_t    state_r, state_nxt;
  hsq_pkg::acc_stat_t stat;

  logic [N_W-1:0]          n_r;
  logic [SIDX_W-1:0]       i_r, i_nxt, j_r, j_nxt, last_x;
  logic signed [SUM_W-1:0] a_r, a_nxt, rd_sum;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_flag_r, out_flag_nxt;
  logic                    verdict_r, verdict_nxt;
  logic                    rd_en;
  logic [SIDX_W-1:0]       rd_idx;
  logic                    in_fire, cfg_fire;

  // Clamp a written side length to the supported range
  function automatic logic [N_W-1:0] clamp_size(input logic [hsq_pkg::SIZE_W-1:0] s);
    logic [N_W-1:0] n;
    if (s == '0) begin
      n = N_W'(1);
    end else if (32'(s) > MAX_SIZE) begin
      n = N_W'(MAX_SIZE);
    end else begin
      n = N_W'(s);
    end
    return n;
  endfunction

  // Hold the input while a size write is offered or the block is not loading
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = (state_r == hsq_pkg::ST_LOAD);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_stall  = (state_r != hsq_pkg::ST_LOAD) || cfg_valid;
  assign last_x    = SIDX_W'(n_r) + SIDX_W'(n_r) + 1'b1;

  assign out_valid           = out_valid_r;
  assign out_is_heterosquare = out_flag_r;

  hsq_accum #(
    .MAX_SIZE      (MAX_SIZE),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (cfg_fire),
    .size_n  (n_r),
    .in_fire (in_fire),
    .in_elem (in_element_value),
    .stat    (stat),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx),
    .rd_sum  (rd_sum)
  );

  // Sequence loading, the pairwise scan and the result hand-off
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    a_nxt         = a_r;
    verdict_nxt   = verdict_r;
    out_flag_nxt  = out_flag_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_en         = 1'b0;
    rd_idx        = i_r;
    case (state_r)
      hsq_pkg::ST_LOAD: begin
        if (in_fire && stat.last_item) begin
          state_nxt = hsq_pkg::ST_FLUSH;
        end
      end
      hsq_pkg::ST_FLUSH: begin
        i_nxt     = '0;
        state_nxt = hsq_pkg::ST_FETCH_A;
      end
      hsq_pkg::ST_FETCH_A: begin
        rd_en     = 1'b1;
        rd_idx    = i_r;
        state_nxt = hsq_pkg::ST_LOAD_A;
      end
      hsq_pkg::ST_LOAD_A: begin
        a_nxt     = rd_sum;
        rd_en     = 1'b1;
        rd_idx    = i_r + 1'b1;
        j_nxt     = i_r + 1'b1;
        state_nxt = hsq_pkg::ST_SCAN;
      end
      hsq_pkg::ST_SCAN: begin
        if (rd_sum == a_r) begin
          verdict_nxt = 1'b0;
          state_nxt   = hsq_pkg::ST_DONE;
        end else if (j_r == last_x) begin
          if (i_r + 1'b1 == last_x) begin
            verdict_nxt = 1'b1;
            state_nxt   = hsq_pkg::ST_DONE;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = hsq_pkg::ST_FETCH_A;
          end
        end else begin
          rd_en  = 1'b1;
          rd_idx = j_r + 1'b1;
          j_nxt  = j_r + 1'b1;
        end
      end
      hsq_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_flag_nxt  = verdict_r;
          state_nxt     = hsq_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = hsq_pkg::ST_LOAD;
      end
    endcase
  end

  // Hold state, side length and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hsq_pkg::ST_LOAD;
      n_r         <= clamp_size(hsq_pkg::RESET_SIZE);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_fire) begin
        n_r <= clamp_size(cfg_square_size);
      end
    end
  end

  // Scan indexes and payload
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    a_r        <= a_nxt;
    verdict_r  <= verdict_nxt;
    out_flag_r <= out_flag_nxt;
  end

  // The closing element always leads into the writeback flush
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && stat.last_item |=> state_r == hsq_pkg::ST_FLUSH)
    else $error("closing element did not start the check");

  // Memory reads for the check never overlap a column writeback
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hsq_pkg::ST_FETCH_A |-> !stat.wb_pend)
    else $error("check read while column writeback pending");

  // The scan compares only later sums within range
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hsq_pkg::ST_SCAN |-> (j_r > i_r) && (j_r <= last_x))
    else $error("scan index out of order or range");

  // A new result only comes from the finished check
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !$past(out_valid_r) |-> $past(state_r) == hsq_pkg::ST_DONE)
    else $error("result raised outside the done state");

endmodule
